/* sv/bilinear_remap_fixed_point_assert.svh */
// Assertion macros for the bilinear remap block
`ifndef BILINEAR_REMAP_FIXED_POINT_ASSERT_SVH
`define BILINEAR_REMAP_FIXED_POINT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BRM_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define BRM_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define BRM_ASSERT_IMP(label, clk, rst_n, a, c)
`define BRM_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

/* sv/brm_pkg.sv */
// Shared types and constants for the bilinear remap block
package brm_pkg;
    localparam int MaxWidth  = 64;
    localparam int MaxHeight = 64;
    localparam int FracBits  = 9;
    localparam int XW        = $clog2(MaxWidth);
    localparam int YW        = $clog2(MaxHeight);
    localparam int AW        = XW + YW;
    localparam int WW        = FracBits + 1;
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef logic [23:0] pix_t;

    typedef struct packed {
        logic [11:0]      idx;
        logic             clamped;
        logic [3:0][WW-1:0] w;
    } qmeta_t;
endpackage

/* sv/brm_weights.sv */
// Weight generation: fraction products, rounded, registered
module brm_weights (
    input  logic                        clk,
    input  logic                        en,
    input  logic [brm_pkg::FracBits-1:0] fx,
    input  logic [brm_pkg::FracBits-1:0] fy,
    output logic [3:0][brm_pkg::WW-1:0]  w
);
    localparam int F = brm_pkg::FracBits;
    localparam int W = brm_pkg::WW;
    logic [W-1:0] gx, gy;
    logic [2*W-1:0] p [4];
    logic [3:0][W-1:0] w_reg;

    assign gx = (W'(1) << F) - W'(fx);
    assign gy = (W'(1) << F) - W'(fy);
    assign p[0] = gy * gx;
    assign p[1] = gy * W'(fx);
    assign p[2] = W'(fy) * gx;
    assign p[3] = W'(fy) * W'(fx);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
                w_reg[k] <= W'((p[k] + (2*W)'(1 << (F-1))) >> F);
        end
    end
    assign w = w_reg;
endmodule

/* sv/brm_mac.sv */
// One channel: four weight products summed, floored and saturated
module brm_mac (
    input  logic                       clk,
    input  logic                       en1,
    input  logic                       en2,
    input  logic [3:0][brm_pkg::WW-1:0] w,
    input  logic [3:0][7:0]             px,
    output logic [7:0]                  res
);
    localparam int W = brm_pkg::WW;
    localparam int PW = W + 8;
    localparam int SW = PW + 2;
    logic [PW-1:0] prod_reg [4];
    logic [SW-1:0] sum;
    logic [SW-1:0] v;
    logic [7:0] res_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int k = 0; k < 4; k++)
                prod_reg[k] <= PW'(w[k]) * PW'(px[k]);
        end
    end

    assign sum = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]) + SW'(prod_reg[3]);
    assign v = sum >> brm_pkg::FracBits;

    always_ff @(posedge clk)
    begin
        if (en2)
            res_reg <= (v > SW'(255)) ? 8'hFF : v[7:0];
    end
    assign res = res_reg;
endmodule

/* sv/bilinear_remap_fixed_point.sv */
// Bilinear remap top level: pixel store, address/weight stage, MAC stages, output
// Query requests pass the stages below to result valid; loads give no result.
// Stages: clamp+weights, four store reads, products, sum and saturate.
// Throughput: one request per clock, loads and queries alike, unless output stalls.
// Reset: frame_width and frame_height return to 64, pipeline valids clear.
// The pixel store is not cleared; unwritten pixels read as undefined.
`include "bilinear_remap_fixed_point_assert.svh"
module bilinear_remap_fixed_point (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [5:0]  x_int,
    input  logic [5:0]  y_int,
    input  logic [8:0]  x_frac,
    input  logic [8:0]  y_frac,
    input  logic [11:0] dest_index,
    input  logic [7:0]  load_red,
    input  logic [7:0]  load_green,
    input  logic [7:0]  load_blue,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] out_index,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic        edge_clamped
);
    localparam int XW = brm_pkg::XW;
    localparam int YW = brm_pkg::YW;
    localparam int AW = brm_pkg::AW;
    localparam int DEPTH = brm_pkg::MaxWidth * brm_pkg::MaxHeight;

    logic [6:0] fw_reg, fh_reg;
    logic [XW-1:0] fwm1;
    logic [YW-1:0] fhm1;
    logic [3:0] v_reg;
    logic adv;
    logic acc;
    logic [XW:0] x1w;
    logic [YW:0] y1w;
    logic [XW-1:0] x0, x1;
    logic [YW-1:0] y0, y1;
    logic cl;
    logic [3:0][AW-1:0] addr_reg;
    logic [11:0] idx_reg [4];
    logic cl_reg [4];
    logic [3:0][brm_pkg::WW-1:0] w1, w_reg2;
    brm_pkg::pix_t bank0 [DEPTH];
    brm_pkg::pix_t bank1 [DEPTH];
    brm_pkg::pix_t bank2 [DEPTH];
    brm_pkg::pix_t bank3 [DEPTH];
    brm_pkg::pix_t rd [4];
    logic [AW-1:0] waddr;
    logic [3:0][7:0] pr, pg, pb;

    assign adv = !out_valid || out_ready || !v_reg[3];
    assign in_ready = adv;
    assign acc = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= 7'd64;
            fh_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            if (cfg_index == brm_pkg::REG_FRAME_WIDTH)
                fw_reg <= cfg_data;
            else
                fh_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (fw_reg == 7'd0)
            fwm1 = '0;
        else if (fw_reg > 7'(brm_pkg::MaxWidth))
            fwm1 = XW'(brm_pkg::MaxWidth - 1);
        else
            fwm1 = XW'(fw_reg - 7'd1);
        if (fh_reg == 7'd0)
            fhm1 = '0;
        else if (fh_reg > 7'(brm_pkg::MaxHeight))
            fhm1 = YW'(brm_pkg::MaxHeight - 1);
        else
            fhm1 = YW'(fh_reg - 7'd1);
    end

    assign x1w = (XW+1)'(x_int) + (XW+1)'(1);
    assign y1w = (YW+1)'(y_int) + (YW+1)'(1);
    assign x0 = (x_int > fwm1) ? fwm1 : x_int;
    assign y0 = (y_int > fhm1) ? fhm1 : y_int;
    assign x1 = (x1w > (XW+1)'(fwm1)) ? fwm1 : x1w[XW-1:0];
    assign y1 = (y1w > (YW+1)'(fhm1)) ? fhm1 : y1w[YW-1:0];
    assign cl = (x1w > (XW+1)'(fwm1)) || (y1w > (YW+1)'(fhm1));
    assign waddr = {y_int, x_int};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[2:0], acc && (action == brm_pkg::ACT_QUERY)};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            addr_reg[0] <= {y0, x0};
            addr_reg[1] <= {y0, x1};
            addr_reg[2] <= {y1, x0};
            addr_reg[3] <= {y1, x1};
            idx_reg[0] <= dest_index;
            cl_reg[0]  <= cl;
            for (int s = 1; s < 4; s++)
            begin
                idx_reg[s] <= idx_reg[s-1];
                cl_reg[s]  <= cl_reg[s-1];
            end
            w_reg2 <= w1;
        end
    end

    brm_weights u_w (
        .clk (clk), .en (adv), .fx (x_frac), .fy (y_frac), .w (w1)
    );

    always_ff @(posedge clk)
    begin
        if (acc && action == brm_pkg::ACT_LOAD)
        begin
            bank0[waddr] <= {load_red, load_green, load_blue};
            bank1[waddr] <= {load_red, load_green, load_blue};
            bank2[waddr] <= {load_red, load_green, load_blue};
            bank3[waddr] <= {load_red, load_green, load_blue};
        end
        if (adv)
        begin
            rd[0] <= bank0[addr_reg[0]];
            rd[1] <= bank1[addr_reg[1]];
            rd[2] <= bank2[addr_reg[2]];
            rd[3] <= bank3[addr_reg[3]];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            pr[k] = rd[k][23:16];
            pg[k] = rd[k][15:8];
            pb[k] = rd[k][7:0];
        end
    end

    brm_mac u_r (.clk(clk), .en1(adv), .en2(adv), .w(w_reg2), .px(pr), .res(out_red));
    brm_mac u_g (.clk(clk), .en1(adv), .en2(adv), .w(w_reg2), .px(pg), .res(out_green));
    brm_mac u_b (.clk(clk), .en1(adv), .en2(adv), .w(w_reg2), .px(pb), .res(out_blue));

    assign out_valid = v_reg[3];
    assign out_index = idx_reg[3];
    assign edge_clamped = cl_reg[3];

    `BRM_ASSERT_IMP(a_stall_ready, clk, rst_n, out_valid && !out_ready, !in_ready)
    `BRM_ASSERT_NEXT(a_load_no_v, clk, rst_n, acc && action == brm_pkg::ACT_LOAD && adv, !v_reg[0])
    `BRM_ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_index))
endmodule
